FILE: rtl/phdm_pkg.sv
// phdm_pkg: widths, register indexes, reset values and control structs
// for the peak hold decay meter
// no dependencies
package phdm_pkg;

  // field widths
  localparam int LEVEL_IN_W = 8;
  localparam int LEVEL_W    = 7;
  localparam int HOLD_W     = 8;
  localparam int AVG_W      = 8;
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 1;

  // decay divide: numerator is (avg-1)*peak + level, quotient never exceeds peak
  localparam int PROD_W     = AVG_W + LEVEL_W;
  localparam int DIV_STEPS  = LEVEL_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_FACTOR = 1'd1;

  // configuration reset values
  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd5;
  localparam logic [AVG_W-1:0]  AVG_RESET  = 8'd6;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic eval;
    logic div_init;
    logic div_step;
    logic div_last;
    logic emit;
  } phdm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic decay;
    logic new_peak;
  } phdm_sts_t;

endpackage

FILE: rtl/phdm_if.sv
// phdm_in_if and phdm_out_if: valid/ready channels of the meter
// depends on phdm_pkg
interface phdm_in_if import phdm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [LEVEL_IN_W-1:0] level_in;

  modport source (output valid, output level_in, input ready);
  modport sink   (input valid, input level_in, output ready);
endinterface

interface phdm_out_if import phdm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level_out;
  logic [LEVEL_W-1:0] peak_out;

  modport source (output valid, output level_out, output peak_out, input ready);
  modport sink   (input valid, input level_out, input peak_out, output ready);
endinterface

FILE: rtl/peak_hold_decay_meter_core.sv
// peak_hold_decay_meter_core: top level of the peak hold meter with decay
// depends on phdm_pkg, phdm_if, phdm_ctrl and phdm_dp
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          level_in[7:0]
//   out_ch   out  valid/ready          level_out[6:0], peak_out[6:0]
//   cfg      in   cfg_we               cfg_idx[0], cfg_wdata[7:0]
//
// one word at a time: accept, evaluate, then emit when the peak is held or
// replaced; a decaying word adds a divide set-up step and the steps of the
// restoring divider (one quotient bit each) between evaluate and emit
// a result waiting in the output register does not block the next accept;
// emit waits while out_ch stalls with a word still held
// rst_n is synchronous: peak returns to full scale, hold count to zero,
// hold_ticks to 5 and avg_factor to 6
module peak_hold_decay_meter_core import phdm_pkg::*; #(
  parameter int unsigned FULL_SCALE = 80
) (
  input  logic                 clk,
  input  logic                 rst_n,
  phdm_in_if.sink              in_ch,
  phdm_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic [LEVEL_W-1:0] FULL = LEVEL_W'(FULL_SCALE);

  phdm_cmd_t cmd;
  phdm_sts_t sts;

  // sequencer
  phdm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and state
  phdm_dp #(
    .FULL_SCALE (FULL_SCALE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .level_in  (in_ch.level_in),
    .cmd       (cmd),
    .sts       (sts),
    .level_out (out_ch.level_out),
    .peak_out  (out_ch.peak_out)
  );

  // only one word in flight
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a word is in flight");

  // emit never overwrites a word not yet taken
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten");

  // peak never falls below the clamped level
  a_peak_ge_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.peak_out >= out_ch.level_out))
    else $error("peak below level");

  // peak stays within full scale
  a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.peak_out <= FULL))
    else $error("peak above full scale");

endmodule

FILE: rtl/phdm_ctrl.sv
// phdm_ctrl: sequencing state machine for the peak hold decay meter
// depends on phdm_pkg
module phdm_ctrl import phdm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  phdm_sts_t sts,
  output phdm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV_INIT,
    S_DIV,
    S_EMIT
  } state_t;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;
  logic                 out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // commands
  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.eval     = (state_r == S_EVAL);
    cmd.div_init = (state_r == S_DIV_INIT);
    cmd.div_step = (state_r == S_DIV);
    cmd.div_last = (state_r == S_DIV) && (cnt_r == CNT_LAST);
    cmd.emit     = (state_r == S_EMIT) && out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.decay) state_nxt = S_DIV_INIT;
        else           state_nxt = S_EMIT;
      end
      S_DIV_INIT: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid: set on emit, cleared when the word is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)      out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/phdm_dp.sv
// phdm_dp: datapath of the meter: config registers, peak and hold state,
// decay multiply and restoring divider, output register; depends on phdm_pkg
module phdm_dp import phdm_pkg::*; #(
  parameter int unsigned FULL_SCALE = 80
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic [LEVEL_IN_W-1:0] level_in,
  input  phdm_cmd_t             cmd,
  output phdm_sts_t             sts,
  output logic [LEVEL_W-1:0]    level_out,
  output logic [LEVEL_W-1:0]    peak_out
);

  localparam logic [LEVEL_W-1:0] FULL = LEVEL_W'(FULL_SCALE);

  logic [HOLD_W-1:0]  hold_ticks_r;
  logic [AVG_W-1:0]   avg_factor_r;
  logic [LEVEL_W-1:0] peak_r, peak_nxt;
  logic [HOLD_W-1:0]  hold_r, hold_nxt;
  logic [LEVEL_W-1:0] lvl_r;
  logic [PROD_W-1:0]  prod_r;
  logic [AVG_W-1:0]   rem_r;
  logic [LEVEL_W-1:0] quo_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [LEVEL_W-1:0] out_peak_r;

  logic [LEVEL_W-1:0] lvl_clamp;
  logic [AVG_W-1:0]   divisor;
  logic [AVG_W-1:0]   div_m1;
  logic [PROD_W-1:0]  prod_nxt;
  logic [AVG_W:0]     trial;
  logic [AVG_W:0]     diff;
  logic               ge;
  logic [AVG_W-1:0]   rem_nxt;
  logic [LEVEL_W-1:0] quo_nxt;

  // clamp to full scale
  assign lvl_clamp = (level_in > LEVEL_IN_W'(FULL)) ? FULL : level_in[LEVEL_W-1:0];

  // status for the evaluation cycle
  assign sts.new_peak = (lvl_r > peak_r);
  assign sts.decay    = !sts.new_peak && (hold_r == '0);

  // divisor, zero acts as one
  assign divisor = (avg_factor_r == '0) ? AVG_W'(1) : avg_factor_r;
  assign div_m1  = divisor - 1'b1;

  // decay numerator
  assign prod_nxt = PROD_W'(div_m1) * PROD_W'(peak_r) + PROD_W'(lvl_r);

  // one restoring divide step
  assign trial   = {rem_r, quo_r[LEVEL_W-1]};
  assign diff    = trial - {1'b0, divisor};
  assign ge      = (trial >= {1'b0, divisor});
  assign rem_nxt = ge ? diff[AVG_W-1:0] : trial[AVG_W-1:0];
  assign quo_nxt = {quo_r[LEVEL_W-2:0], ge};

  // peak and hold update
  always_comb begin
    peak_nxt = peak_r;
    hold_nxt = hold_r;
    if (cmd.eval) begin
      if (sts.new_peak) begin
        peak_nxt = lvl_r;
        hold_nxt = hold_ticks_r;
      end else if (hold_r != '0) begin
        hold_nxt = hold_r - 1'b1;
      end
    end else if (cmd.div_last) begin
      peak_nxt = quo_nxt;
    end
  end

  // control state and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r <= HOLD_RESET;
      avg_factor_r <= AVG_RESET;
      peak_r       <= FULL;
      hold_r       <= '0;
    end else begin
      peak_r <= peak_nxt;
      hold_r <= hold_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_HOLD_TICKS: hold_ticks_r <= cfg_wdata[HOLD_W-1:0];
          CFG_AVG_FACTOR: avg_factor_r <= cfg_wdata[AVG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) lvl_r <= lvl_clamp;
    if (cmd.eval) prod_r <= prod_nxt;
    if (cmd.div_init) begin
      rem_r <= prod_r[PROD_W-1:LEVEL_W];
      quo_r <= prod_r[LEVEL_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.emit) begin
      out_level_r <= lvl_r;
      out_peak_r  <= peak_r;
    end
  end

  assign level_out = out_level_r;
  assign peak_out  = out_peak_r;

endmodule

FILE: verif/phdm_peak_checker.sv
// phdm_peak_checker: watches the meter's channels and configuration port, keeps its
// own peak, hold and config state, and compares every output word with its prediction
// depends on phdm_pkg
module phdm_peak_checker import phdm_pkg::*; #(
  parameter int unsigned FULL_SCALE = 80
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [LEVEL_IN_W-1:0] in_level,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [LEVEL_W-1:0]    out_level,
  input  logic [LEVEL_W-1:0]    out_peak,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output int unsigned           pending_words,
  output int unsigned           mismatch_total
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] peak;
  } meter_reading_t;

  // predicted meter state and register copies
  logic [LEVEL_W-1:0] peak_q;
  logic [HOLD_W-1:0]  hold_q;
  logic [HOLD_W-1:0]  hold_ticks_q;
  logic [AVG_W-1:0]   avg_factor_q;

  meter_reading_t expected_readings[$];
  meter_reading_t want;
  int unsigned    fails;

  initial begin
    pending_words  = 0;
    mismatch_total = 0;
    fails          = 0;
  end

  // one sample through the meter: clamp, then new peak, hold countdown or decay
  function automatic meter_reading_t meter_update(input logic [LEVEL_IN_W-1:0] raw);
    logic [LEVEL_W-1:0] lvl;
    int unsigned        divisor;
    int unsigned        numer;
    meter_reading_t     r;
    lvl = (raw > FULL_SCALE) ? LEVEL_W'(FULL_SCALE) : raw[LEVEL_W-1:0];
    if (lvl > peak_q) begin
      peak_q = lvl;
      hold_q = hold_ticks_q;
    end else if (hold_q != 0) begin
      hold_q = hold_q - 1'b1;
    end else begin
      divisor = (avg_factor_q == 0) ? 1 : avg_factor_q;
      numer   = (divisor - 1) * peak_q + lvl;
      peak_q  = LEVEL_W'(numer / divisor);
    end
    r.level = lvl;
    r.peak  = peak_q;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      peak_q       = LEVEL_W'(FULL_SCALE);
      hold_q       = '0;
      hold_ticks_q = HOLD_RESET;
      avg_factor_q = AVG_RESET;
      expected_readings.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_idx)
          CFG_HOLD_TICKS: hold_ticks_q = cfg_wdata[HOLD_W-1:0];
          CFG_AVG_FACTOR: avg_factor_q = cfg_wdata[AVG_W-1:0];
          default: ;
        endcase
      end
      // accepted sample
      if (in_valid && in_ready) begin
        expected_readings.push_back(meter_update(in_level));
      end
      // accepted output word
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected word, expected none, got level %0d peak %0d",
                   $time, out_level, out_peak);
          fails++;
        end else begin
          want = expected_readings.pop_front();
          if (out_level !== want.level) begin
            $display("%0t: level_out mismatch, expected %0d, got %0d",
                     $time, want.level, out_level);
            fails++;
          end
          if (out_peak !== want.peak) begin
            $display("%0t: peak_out mismatch, expected %0d, got %0d",
                     $time, want.peak, out_peak);
            fails++;
          end
        end
      end
    end
    pending_words  <= expected_readings.size();
    mismatch_total <= fails;
  end

endmodule

FILE: verif/tb_top.sv
// tb_top: clock, reset and stimulus for peak_hold_decay_meter_core, with the verdict
// depends on phdm_pkg, phdm_if, the core and phdm_peak_checker
module tb_top import phdm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned METER_FULL_SCALE = 80;
  localparam int unsigned HOLD_OFF_CYCLES  = 80;
  localparam int unsigned CHUNK_WORDS      = 77;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off_req;
  int unsigned pending_words;
  int unsigned mismatch_total;

  phdm_in_if  in_ch ();
  phdm_out_if out_ch ();

  peak_hold_decay_meter_core #(
    .FULL_SCALE(METER_FULL_SCALE)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  phdm_peak_checker #(
    .FULL_SCALE(METER_FULL_SCALE)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_level      (in_ch.level_in),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_level     (out_ch.level_out),
    .out_peak      (out_ch.peak_out),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .pending_words (pending_words),
    .mismatch_total(mismatch_total)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random back-pressure, or a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one sample, with random gaps ahead of it, until it is taken
  task automatic send_sample(input logic [LEVEL_IN_W-1:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.level_in <= raw;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait until every predicted word has come out
  task automatic drain_meter();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // write both registers while the meter is idle
  task automatic set_meter(input logic [HOLD_W-1:0] hold, input logic [AVG_W-1:0] avg);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_HOLD_TICKS;
    cfg_wdata <= CFG_W'(hold);
    @(posedge clk);
    cfg_idx   <= CFG_AVG_FACTOR;
    cfg_wdata <= CFG_W'(avg);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly quiet samples so the hold runs out and decay shows, with peaks and overloads
  function automatic logic [LEVEL_IN_W-1:0] pick_level();
    int unsigned mode;
    mode = $urandom_range(9);
    case (mode)
      0:       return LEVEL_IN_W'($urandom_range(255));
      1:       return LEVEL_IN_W'($urandom_range(255, 81));
      2, 3:    return LEVEL_IN_W'($urandom_range(80, 60));
      default: return LEVEL_IN_W'($urandom_range($urandom_range(80)));
    endcase
  endfunction

  initial begin
    logic [HOLD_W-1:0] hold;
    logic [AVG_W-1:0]  avg;
    int unsigned       chunk;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_HOLD_TICKS;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.level_in = '0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_off_req   = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: overload, equal to peak, decay with no hold after reset, then a new peak
    send_sample(8'd255);
    send_sample(8'd80);
    repeat (8) send_sample(8'd0);
    send_sample(8'd40);
    send_sample(8'd81);
    send_sample(8'd128);
    drain_meter();

    // zero hold and zero divisor: decay snaps straight to the sample
    set_meter(8'd0, 8'd0);
    send_sample(8'd0);
    send_sample(8'd50);
    send_sample(8'd50);
    send_sample(8'd20);
    send_sample(8'd255);
    send_sample(8'd10);
    drain_meter();

    // longest hold and largest divisor
    set_meter(8'd255, 8'd255);
    send_sample(8'd255);
    repeat (3) send_sample(8'd0);
    send_sample(8'd80);
    drain_meter();

    // random part in three idling phases, new settings for every chunk
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 19; recv_idle_pct = 66; end
        1: begin send_idle_pct = 66; recv_idle_pct = 19; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int k = 0; k < 4; k++) begin
        chunk = phase * 4 + k;
        case (chunk)
          0: begin hold = 8'd0;   avg = 8'd0;   end
          1: begin hold = 8'd255; avg = 8'd255; end
          2: begin hold = 8'd0;   avg = 8'd255; end
          3: begin hold = 8'd255; avg = 8'd0;   end
          default: begin
            hold = ($urandom_range(7) == 0) ? HOLD_W'($urandom_range(255))
                                            : HOLD_W'($urandom_range(4));
            avg  = ($urandom_range(3) == 0) ? AVG_W'($urandom_range(255))
                                            : AVG_W'($urandom_range(12));
          end
        endcase
        set_meter(hold, avg);
        // long receiver hold-off while samples keep coming, so the input stalls
        if (phase == 2 && k == 0) hold_off_req = 1'b1;
        for (int n = 0; n < CHUNK_WORDS; n++) send_sample(pick_level());
        drain_meter();
      end
    end

    repeat (20) @(posedge clk);
    if (mismatch_total == 0 && pending_words == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: peak_hold_decay_meter_core.f
rtl/phdm_pkg.sv
rtl/phdm_if.sv
rtl/phdm_ctrl.sv
rtl/phdm_dp.sv
rtl/peak_hold_decay_meter_core.sv
verif/phdm_peak_checker.sv
verif/tb_top.sv
